/* rtl/pcmd_pkg.sv */
// Shared widths, register indexes and divider status for the PCM decimator.
package pcmd_pkg;

  // Field and register widths
  localparam int unsigned WORD_W   = 16;
  localparam int unsigned U8_W     = 8;
  localparam int unsigned SUM_W    = 11;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned FACT_W   = 4;
  localparam int unsigned CHAN_W   = 2;
  localparam int unsigned CFG_W    = 4;
  localparam int unsigned CFG_IDX_W = 2;

  // Largest box length; factors above it saturate
  localparam int unsigned MaxDecimation = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNELS   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECIMATION = 2'd2;

  // Serial divider: one quotient bit per cycle over the whole group sum
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int unsigned REM_W     = FACT_W;

  // Divider status toward the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* rtl/pcmd_div.sv */
// Bit-serial restoring divider: group sum over the effective factor.
module pcmd_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [pcmd_pkg::SUM_W-1:0]    dividend,
  input  logic [pcmd_pkg::FACT_W-1:0]   divisor,
  output pcmd_pkg::div_stat_t           stat,
  output logic [pcmd_pkg::SUM_W-1:0]    quotient
);

  logic                            busy_r, busy_nxt;
  logic                            done_r, done_nxt;
  logic [pcmd_pkg::DIV_CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [pcmd_pkg::REM_W-1:0]      rem_r, rem_nxt;
  logic [pcmd_pkg::SUM_W-1:0]      quo_r, quo_nxt;
  logic [pcmd_pkg::FACT_W-1:0]     div_r, div_nxt;
  logic [pcmd_pkg::REM_W+1:0]      trial;

  // Try to subtract the divisor from the shifted partial remainder
  assign trial = {1'b0, rem_r, quo_r[pcmd_pkg::SUM_W-1]} - {2'b00, div_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      // load operands
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      // shift in one quotient bit; take the difference when no borrow,
      // else keep the shifted remainder
      if (!trial[pcmd_pkg::REM_W+1]) begin
        rem_nxt = trial[pcmd_pkg::REM_W-1:0];
      end else begin
        rem_nxt = {rem_r[pcmd_pkg::REM_W-2:0], quo_r[pcmd_pkg::SUM_W-1]};
      end
      quo_nxt = {quo_r[pcmd_pkg::SUM_W-2:0], ~trial[pcmd_pkg::REM_W+1]};
      if (cnt_r == pcmd_pkg::DIV_CNT_W'(pcmd_pkg::DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // operand and result registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* rtl/pcm_to_u8_mono_decimator_core.sv */
// Top level: PCM to unsigned 8-bit mono conversion with box-filter decimation.
//
//  channel  | ports                                  | direction
//  ---------+----------------------------------------+----------
//  input    | in_valid, in_stall, in_sample_word,    | in
//           | in_start_of_stream                     |
//  result   | out_valid, out_stall, out_sample_out   | out
//  config   | cfg_we, cfg_index, cfg_wdata           | in
//
// A word that does not close a group is taken without stalling. A word that
// closes a group starts the bit-serial divider (one quotient bit per cycle),
// and the mean is then loaded into the output register; the input stalls
// while the divider runs and until that load is made.
// Reset clears configuration to 16-bit mono, factor 1, and empties the pending group and output valid.
// A stalled result stays in the output register; the next word is taken
// while it waits, and a new mean waits until the register frees.
module pcm_to_u8_mono_decimator_core (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pcmd_pkg::WORD_W-1:0]     in_sample_word,
  input  logic                            in_start_of_stream,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [pcmd_pkg::U8_W-1:0]       out_sample_out,
  input  logic                            cfg_we,
  input  logic [pcmd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pcmd_pkg::CFG_W-1:0]      cfg_wdata
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            mode_r;
  logic [pcmd_pkg::CHAN_W-1:0]     chan_r;
  logic [pcmd_pkg::FACT_W-1:0]     fact_r;
  logic [pcmd_pkg::U8_W-1:0]       held_r, held_nxt;
  logic                            phase_r, phase_nxt;
  logic [pcmd_pkg::SUM_W-1:0]      sum_r, sum_nxt;
  logic [pcmd_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [pcmd_pkg::U8_W-1:0]       out_data_r, out_data_nxt;

  logic                            in_accept;
  logic                            out_free;
  logic [pcmd_pkg::WORD_W-1:0]     flip_w;
  logic [pcmd_pkg::WORD_W-1:0]     dec_w;
  logic [pcmd_pkg::U8_W-1:0]       conv;
  logic [pcmd_pkg::U8_W:0]         pair_sum;
  logic [pcmd_pkg::U8_W-1:0]       mono;
  logic [pcmd_pkg::FACT_W-1:0]     fact_eff;
  logic                            stereo;
  logic [pcmd_pkg::U8_W-1:0]       held_cur;
  logic                            phase_cur;
  logic [pcmd_pkg::SUM_W-1:0]      sum_cur, sum_add;
  logic [pcmd_pkg::CNT_W-1:0]      cnt_cur;
  logic [pcmd_pkg::CNT_W:0]        cnt_add;
  logic                            div_start;
  pcmd_pkg::div_stat_t             div_stat;
  logic [pcmd_pkg::SUM_W-1:0]      div_quo;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b1;
      chan_r <= pcmd_pkg::CHAN_W'(1);
      fact_r <= pcmd_pkg::FACT_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        pcmd_pkg::REG_WIDTH_MODE: mode_r <= cfg_wdata[0];
        pcmd_pkg::REG_CHANNELS:   chan_r <= cfg_wdata[pcmd_pkg::CHAN_W-1:0];
        pcmd_pkg::REG_DECIMATION: fact_r <= cfg_wdata[pcmd_pkg::FACT_W-1:0];
        default: ;
      endcase
    end
  end

  // Convert the word: 16-bit mode takes the offset-binary high byte, underflow clamped to zero; 8-bit mode the low byte
  assign flip_w = in_sample_word ^ {1'b1, {(pcmd_pkg::WORD_W-1){1'b0}}};
  assign dec_w  = flip_w - pcmd_pkg::WORD_W'(1);
  always_comb begin
    if (!mode_r) begin
      conv = in_sample_word[pcmd_pkg::U8_W-1:0];
    end else if (flip_w == '0) begin
      conv = '0;
    end else begin
      conv = dec_w[pcmd_pkg::WORD_W-1:pcmd_pkg::WORD_W-pcmd_pkg::U8_W];
    end
  end

  // Effective factor: zero acts as one, large values saturate
  always_comb begin
    if (fact_r == '0) begin
      fact_eff = pcmd_pkg::FACT_W'(1);
    end else if (fact_r > pcmd_pkg::FACT_W'(pcmd_pkg::MaxDecimation)) begin
      fact_eff = pcmd_pkg::FACT_W'(pcmd_pkg::MaxDecimation);
    end else begin
      fact_eff = fact_r;
    end
  end

  assign stereo = (chan_r == pcmd_pkg::CHAN_W'(2));

  // Drop pending state on start of stream
  assign held_cur  = in_start_of_stream ? '0   : held_r;
  assign phase_cur = in_start_of_stream ? 1'b0 : phase_r;
  assign sum_cur   = in_start_of_stream ? '0   : sum_r;
  assign cnt_cur   = in_start_of_stream ? '0   : cnt_r;

  // Downmix and accumulate
  assign pair_sum = {1'b0, held_cur} + {1'b0, conv};
  assign mono     = stereo ? pair_sum[pcmd_pkg::U8_W:1] : conv;
  assign sum_add  = sum_cur + {{(pcmd_pkg::SUM_W-pcmd_pkg::U8_W){1'b0}}, mono};
  assign cnt_add  = {1'b0, cnt_cur} + 1'b1;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    phase_nxt     = phase_r;
    sum_nxt       = sum_r;
    cnt_nxt       = cnt_r;
    div_start     = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // retire a taken result
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          held_nxt = held_cur;
          sum_nxt  = sum_cur;
          cnt_nxt  = cnt_cur;
          if (stereo && !phase_cur) begin
            // hold the first channel for its partner
            held_nxt  = conv;
            phase_nxt = 1'b1;
          end else begin
            phase_nxt = 1'b0;
            if (cnt_add >= {1'b0, fact_eff}) begin
              // close the group and start the mean
              sum_nxt   = '0;
              cnt_nxt   = '0;
              div_start = 1'b1;
              state_nxt = ST_DIV;
            end else begin
              sum_nxt = sum_add;
              cnt_nxt = cnt_add[pcmd_pkg::CNT_W-1:0];
            end
          end
        end
      end
      ST_DIV: begin
        if (div_stat.done) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_data_nxt  = div_quo[pcmd_pkg::U8_W-1:0];
            state_nxt     = ST_IDLE;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        // wait for the output register to free
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = div_quo[pcmd_pkg::U8_W-1:0];
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      held_r      <= '0;
      phase_r     <= 1'b0;
      sum_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      phase_r     <= phase_nxt;
      sum_r       <= sum_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  pcmd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_add),
    .divisor  (fact_eff),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_data_r;

endmodule
